>>> src/slt_pkg.sv
// Shared types and codes for the shared/exclusive lock table.
package slt_pkg;

   // Request opcodes
   localparam logic [1:0] OP_TRY_LOCK      = 2'd0;
   localparam logic [1:0] OP_TRY_UNLOCK    = 2'd1;
   localparam logic [1:0] OP_LOCK_DONE     = 2'd2;
   localparam logic [1:0] OP_UNLOCK_DONE   = 2'd3;

   // Response codes
   localparam logic [1:0] RC_FAIL          = 2'd0;
   localparam logic [1:0] RC_RETRY         = 2'd1;
   localparam logic [1:0] RC_PASS          = 2'd2;
   localparam logic [1:0] RC_DONE          = 2'd3;

   // Entry pending status
   localparam logic [1:0] PEND_IDLE        = 2'd0;
   localparam logic [1:0] PEND_LOCKING     = 2'd1;
   localparam logic [1:0] PEND_UNLOCKING   = 2'd2;

   // Global result of a completion
   localparam logic [1:0] GR_FAILED        = 2'd0;
   localparam logic [1:0] GR_SUCCESS       = 2'd1;
   localparam logic [1:0] GR_QUEUED        = 2'd2;

   localparam logic [15:0] HOLDER_MAX      = 16'hFFFF;

   typedef struct packed {
      logic [15:0] holders;
      logic [15:0] owner;
      logic [1:0]  pending;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic mem_rd;
      logic exec;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } ctl_sts_type;

endpackage

>>> src/shared_exclusive_lock_table_core.sv
// Shared/exclusive lock table: top level joining controller and datapath.
// Sequence: an accepted request passes through the read, update and response states in turn.
// Only one request is in flight: no new request is taken until its response has been
// transferred, as the entry is read, updated and written back and the response is held.
// Reset: synchronous; afterward the table is cleared one entry per cycle, all
// NODE_COUNT*OBJECT_COUNT entries (4096 by default), while requests are stalled.
module shared_exclusive_lock_table_core #(
   parameter int NODE_COUNT   = 16,
   parameter int OBJECT_COUNT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_node,
   input  logic [7:0]  req_object,
   input  logic [15:0] req_user,
   input  logic        req_exclusive_mode,
   input  logic [1:0]  req_global_result,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_code,
   output logic [15:0] rsp_holders,
   output logic [15:0] rsp_owner,
   output logic [1:0]  rsp_pending
);

   slt_pkg::ctl_cmd_type cmd;
   slt_pkg::ctl_sts_type sts;

   slt_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   slt_datapath #(
      .NODE_COUNT   (NODE_COUNT),
      .OBJECT_COUNT (OBJECT_COUNT)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_opcode),
      .req_node           (req_node),
      .req_object         (req_object),
      .req_user           (req_user),
      .req_exclusive_mode (req_exclusive_mode),
      .req_global_result  (req_global_result),
      .rsp_code           (rsp_code),
      .rsp_holders        (rsp_holders),
      .rsp_owner          (rsp_owner),
      .rsp_pending        (rsp_pending)
   );

endmodule

>>> src/slt_datapath.sv
// Lock table datapath: entry memory, clear sweep, request registers and update logic.
module slt_datapath #(
   parameter int NODE_COUNT   = 16,
   parameter int OBJECT_COUNT = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  slt_pkg::ctl_cmd_type cmd,
   output slt_pkg::ctl_sts_type sts,
   input  logic [1:0]           req_opcode,
   input  logic [3:0]           req_node,
   input  logic [7:0]           req_object,
   input  logic [15:0]          req_user,
   input  logic                 req_exclusive_mode,
   input  logic [1:0]           req_global_result,
   output logic [1:0]           rsp_code,
   output logic [15:0]          rsp_holders,
   output logic [15:0]          rsp_owner,
   output logic [1:0]           rsp_pending
);

   localparam int ENTRIES = NODE_COUNT * OBJECT_COUNT;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   slt_pkg::entry_type mem [ENTRIES];

   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               in_range_ff, in_range_in;
   logic [1:0]         op_ff;
   logic [15:0]        user_ff;
   logic               excl_ff;
   logic [1:0]         gres_ff;
   slt_pkg::entry_type rd_ff;
   slt_pkg::entry_type new_entry;
   logic [1:0]         new_code;
   logic [1:0]         code_ff;
   slt_pkg::entry_type out_ff;

   // clear sweep address
   always_comb begin
      clr_in = cmd.clear_wr ? clr_ff + IDX_W'(1) : clr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   assign sts.clear_last = (clr_ff == IDX_W'(ENTRIES - 1));

   // request capture
   always_comb begin
      in_range_in = (32'(req_node) < NODE_COUNT) && (32'(req_object) < OBJECT_COUNT);
      idx_in      = IDX_W'(32'(req_node) * 32'(OBJECT_COUNT) + 32'(req_object));
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff      <= idx_in;
         in_range_ff <= in_range_in;
         op_ff       <= req_opcode;
         user_ff     <= req_user;
         excl_ff     <= req_exclusive_mode;
         gres_ff     <= req_global_result;
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         mem[clr_ff] <= '0;
      end else if (cmd.exec && in_range_ff) begin
         mem[idx_ff] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_ff <= mem[idx_ff];
      end
   end

   // entry update
   always_comb begin
      new_entry = rd_ff;
      new_code  = slt_pkg::RC_FAIL;
      unique case (op_ff)
         slt_pkg::OP_TRY_LOCK: begin
            if (rd_ff.pending != slt_pkg::PEND_IDLE) begin
               new_code = slt_pkg::RC_FAIL;
            end else if (!excl_ff) begin
               if (rd_ff.owner != 16'd0) begin
                  new_code = slt_pkg::RC_FAIL;
               end else if (rd_ff.holders == 16'd0) begin
                  new_entry.pending = slt_pkg::PEND_LOCKING;
                  new_code          = slt_pkg::RC_RETRY;
               end else begin
                  if (rd_ff.holders != slt_pkg::HOLDER_MAX) begin
                     new_entry.holders = rd_ff.holders + 16'd1;
                  end
                  new_code = slt_pkg::RC_PASS;
               end
            end else if (rd_ff.owner == user_ff && rd_ff.holders == 16'd0) begin
               new_code = slt_pkg::RC_PASS;
            end else if (rd_ff.owner != 16'd0 || rd_ff.holders != 16'd0) begin
               new_code = slt_pkg::RC_FAIL;
            end else begin
               new_entry.pending = slt_pkg::PEND_LOCKING;
               new_code          = slt_pkg::RC_RETRY;
            end
         end
         slt_pkg::OP_TRY_UNLOCK: begin
            if (rd_ff.pending != slt_pkg::PEND_IDLE) begin
               new_code = slt_pkg::RC_FAIL;
            end else if (!excl_ff) begin
               if (rd_ff.holders > 16'd1) begin
                  new_entry.holders = rd_ff.holders - 16'd1;
                  new_code          = slt_pkg::RC_PASS;
               end else if (rd_ff.holders == 16'd1) begin
                  new_entry.pending = slt_pkg::PEND_UNLOCKING;
                  new_code          = slt_pkg::RC_RETRY;
               end else begin
                  new_code = slt_pkg::RC_PASS;
               end
            end else if (rd_ff.owner == user_ff) begin
               new_entry.pending = slt_pkg::PEND_UNLOCKING;
               new_code          = slt_pkg::RC_RETRY;
            end else begin
               new_code = slt_pkg::RC_PASS;
            end
         end
         slt_pkg::OP_LOCK_DONE: begin
            new_entry.pending = slt_pkg::PEND_IDLE;
            new_code          = slt_pkg::RC_DONE;
            if (gres_ff == slt_pkg::GR_SUCCESS || gres_ff == slt_pkg::GR_QUEUED) begin
               if (!excl_ff) begin
                  if (rd_ff.holders != slt_pkg::HOLDER_MAX) begin
                     new_entry.holders = rd_ff.holders + 16'd1;
                  end
               end else begin
                  new_entry.owner = user_ff;
               end
            end
         end
         slt_pkg::OP_UNLOCK_DONE: begin
            new_entry.pending = slt_pkg::PEND_IDLE;
            new_code          = slt_pkg::RC_DONE;
            if (gres_ff == slt_pkg::GR_SUCCESS) begin
               if (!excl_ff) begin
                  if (rd_ff.holders != 16'd0) begin
                     new_entry.holders = rd_ff.holders - 16'd1;
                  end
               end else if (rd_ff.owner == user_ff) begin
                  new_entry.owner = 16'd0;
               end
            end
         end
         default: begin
            new_code = slt_pkg::RC_FAIL;
         end
      endcase
   end

   // response registers; an out-of-range index answers fail with an empty entry
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (in_range_ff) begin
            code_ff <= new_code;
            out_ff  <= new_entry;
         end else begin
            code_ff <= slt_pkg::RC_FAIL;
            out_ff  <= '0;
         end
      end
   end

   assign rsp_code    = code_ff;
   assign rsp_holders = out_ff.holders;
   assign rsp_owner   = out_ff.owner;
   assign rsp_pending = out_ff.pending;

   a_oor_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && !in_range_ff |=> code_ff == slt_pkg::RC_FAIL && out_ff == '0)
      else $error("out-of-range request changed response fields");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && in_range_ff &&
      (op_ff == slt_pkg::OP_LOCK_DONE || op_ff == slt_pkg::OP_UNLOCK_DONE)
      |=> code_ff == slt_pkg::RC_DONE && out_ff.pending == slt_pkg::PEND_IDLE)
      else $error("completion did not leave entry idle");

   a_retry_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && in_range_ff && new_code == slt_pkg::RC_RETRY
      |=> out_ff.pending != slt_pkg::PEND_IDLE)
      else $error("retry answer without pending status");

endmodule

>>> src/slt_controller.sv
// Lock table controller: clear sweep, read, update and response sequencing.
module slt_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output slt_pkg::ctl_cmd_type cmd,
   input  slt_pkg::ctl_sts_type sts
);

   slt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slt_pkg::ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = slt_pkg::ST_IDLE;
            end
         end
         slt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = slt_pkg::ST_READ;
            end
         end
         slt_pkg::ST_READ: begin
            state_in = slt_pkg::ST_EXEC;
         end
         slt_pkg::ST_EXEC: begin
            state_in = slt_pkg::ST_RESP;
         end
         slt_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               state_in = slt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slt_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         slt_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         slt_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         slt_pkg::ST_READ: begin
            cmd.mem_rd = 1'b1;
         end
         slt_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         slt_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_no_accept_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("request taken before table clear finished");

   a_capture_to_read: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.mem_rd ##1 cmd.exec ##1 rsp_valid)
      else $error("request sequence broken");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall && !cmd.capture)
      else $error("new request taken while response outstanding");

endmodule
